// ===== hdl/mlst_pkg.sv =====
// shared types and constants of the mac learning table
package mlst_pkg;

  localparam int MAC_W  = 48;
  localparam int PORT_W = 4;
  localparam int CMD_W  = 2;
  localparam int ACT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [ACT_W-1:0] ACT_FLOOD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UNICAST = 2'd1;
  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd2;

  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  // request held by the top level and seen by every cell
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [MAC_W-1:0]  key;        // source mac of a frame, key of a delete
    logic [MAC_W-1:0]  dst;
    logic [PORT_W-1:0] port;
    logic              dst_bcast;
    logic              dst_is_src;
  } req_t;

  // status handed from cell to cell along with the token
  typedef struct packed {
    logic              src_hit;
    logic              reserved;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
    logic              changed;
  } flags_t;

  // end of scan, broadcast to all cells
  typedef struct packed {
    logic fin;
    logic commit;
  } ctl_t;

endpackage

// ===== hdl/mlst_cell.sv =====
// one table entry with its compare logic and token stage
module mlst_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  mlst_pkg::req_t   req,
  input  mlst_pkg::ctl_t   ctl,
  input  logic            tok_i,
  input  mlst_pkg::flags_t flg_i,
  output logic            tok_o,
  output mlst_pkg::flags_t flg_o
);

  logic                      valid_r, valid_nxt;
  logic                      pend_r, pend_nxt;
  logic [mlst_pkg::MAC_W-1:0]  mac_r, mac_nxt;
  logic [mlst_pkg::PORT_W-1:0] port_r, port_nxt;
  logic                      tok_r;
  mlst_pkg::flags_t          flg_r, flg_nxt;
  logic                      key_match;
  logic                      dst_match;

  assign key_match = valid_r && (mac_r == req.key);
  assign dst_match = valid_r && (mac_r == req.dst);

  always_comb begin
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    mac_nxt   = mac_r;
    port_nxt  = port_r;
    flg_nxt   = flg_i;
    if (tok_i) begin
      case (req.cmd)
        mlst_pkg::CMD_FRAME: begin
          if (key_match) begin
            flg_nxt.src_hit = 1'b1;
            if (port_r != req.port) begin
              port_nxt        = req.port;
              flg_nxt.changed = 1'b1;
            end
          end
          if (dst_match) begin
            flg_nxt.dst_hit  = 1'b1;
            flg_nxt.dst_port = port_r;
          end
          // lowest free slot takes the source tentatively
          if (!valid_r && !flg_i.reserved && !flg_i.src_hit) begin
            pend_nxt         = 1'b1;
            mac_nxt          = req.key;
            port_nxt         = req.port;
            flg_nxt.reserved = 1'b1;
          end
        end
        mlst_pkg::CMD_DELETE: begin
          if (key_match) begin
            valid_nxt       = 1'b0;
            flg_nxt.changed = 1'b1;
          end
        end
        mlst_pkg::CMD_CLEAR: begin
          if (valid_r) begin
            valid_nxt       = 1'b0;
            flg_nxt.changed = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (ctl.fin) begin
      pend_nxt = 1'b0;
      if (pend_r && ctl.commit) begin
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      tok_r   <= tok_i;
    end
  end

  always_ff @(posedge clk) begin
    mac_r  <= mac_nxt;
    port_r <= port_nxt;
    flg_r  <= flg_nxt;
  end

  assign tok_o = tok_r;
  assign flg_o = flg_r;

endmodule

// ===== hdl/mac_learning_switch_table.sv =====
// top level of the layer-2 learning bridge mac table
//
// usage:
//   a request is taken on the rising edge where start is high and busy is low.
//   in_command selects frame header, delete of in_key_mac, or clear of the table.
//   a frame learns its source mac on in_in_port, then looks up in_dst_mac.
//   exactly one result follows each request, marked by out_valid for one cycle;
//   the receiver cannot stall, so results are never held back.
// structure:
//   the table is a row of ENTRIES cells; a token walks the row one cell a cycle,
//   each cell compares its entry against the request and passes hit flags on.
//   a new source is parked in the lowest free cell and committed at scan end
//   only if no cell held it already.
// results:
//   frames, deletes and clears answer on out_valid once the token has walked
//   the whole cell row, set by that walk; busy stays high meanwhile.
//   unused commands and frames from a port at or above NUM_PORTS need no scan
//   and answer in the cycle after they are taken. busy drops as out_valid rises,
//   so the next request may be taken at the edge that ends the result cycle.
// reset:
//   synchronous, active low; all valid bits clear, so the table starts empty.
module mac_learning_switch_table #(
  parameter int ENTRIES   = 64,
  parameter int NUM_PORTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [mlst_pkg::CMD_W-1:0]  in_command,
  input  logic [mlst_pkg::MAC_W-1:0]  in_src_mac,
  input  logic [mlst_pkg::MAC_W-1:0]  in_dst_mac,
  input  logic [mlst_pkg::PORT_W-1:0] in_in_port,
  input  logic [mlst_pkg::MAC_W-1:0]  in_key_mac,
  output logic                        out_valid,
  output logic [mlst_pkg::ACT_W-1:0]  out_action,
  output logic [mlst_pkg::PORT_W-1:0] out_out_port,
  output logic                        out_table_changed,
  output logic                        out_learn_dropped
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                       state_r;
  mlst_pkg::req_t               req_r;
  logic                         inj_r;
  logic                         out_valid_r;
  logic [mlst_pkg::ACT_W-1:0]   action_r;
  logic [mlst_pkg::PORT_W-1:0]  port_r;
  logic                         changed_r;
  logic                         dropped_r;

  // token and flag chain; index 0 feeds the first cell
  logic             [ENTRIES:0] tok_w;
  mlst_pkg::flags_t             flg_w [ENTRIES+1];
  mlst_pkg::ctl_t               ctl;

  logic                         accept;
  logic                         needs_scan;
  logic                         scan_done;
  mlst_pkg::flags_t             fin_flg;
  logic                         is_frame;
  logic                         learned;

  // result decision at the end of the scan
  logic [mlst_pkg::ACT_W-1:0]   res_action;
  logic [mlst_pkg::PORT_W-1:0]  res_port;
  logic                         res_changed;
  logic                         res_dropped;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // frames from an out-of-range port and unused commands skip the scan
  assign needs_scan = ((in_command == mlst_pkg::CMD_FRAME) &&
                       (32'(in_in_port) < NUM_PORTS)) ||
                      (in_command == mlst_pkg::CMD_DELETE) ||
                      (in_command == mlst_pkg::CMD_CLEAR);

  assign tok_w[0]  = inj_r;
  assign flg_w[0]  = '0;
  assign scan_done = (state_r == ST_SCAN) && tok_w[ENTRIES];
  assign fin_flg   = flg_w[ENTRIES];
  assign is_frame  = (req_r.cmd == mlst_pkg::CMD_FRAME);

  // source is in the table after this frame, either found or newly placed
  assign learned = fin_flg.src_hit || fin_flg.reserved;

  assign ctl.fin    = scan_done;
  assign ctl.commit = scan_done && is_frame && !fin_flg.src_hit && fin_flg.reserved;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      mlst_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_r),
        .ctl   (ctl),
        .tok_i (tok_w[gi]),
        .flg_i (flg_w[gi]),
        .tok_o (tok_w[gi+1]),
        .flg_o (flg_w[gi+1])
      );
    end
  endgenerate

  always_comb begin
    res_action  = mlst_pkg::ACT_NONE;
    res_port    = '0;
    res_changed = fin_flg.changed;
    res_dropped = 1'b0;
    if (is_frame) begin
      res_changed = fin_flg.changed || ctl.commit;
      res_dropped = !learned;
      if (req_r.dst_bcast) begin
        res_action = mlst_pkg::ACT_FLOOD;
      end else if (req_r.dst_is_src) begin
        // lookup follows learning, so the frame goes back where it came from
        if (learned) begin
          res_action = mlst_pkg::ACT_UNICAST;
          res_port   = req_r.port;
        end else begin
          res_action = mlst_pkg::ACT_FLOOD;
        end
      end else if (fin_flg.dst_hit) begin
        if (32'(fin_flg.dst_port) < NUM_PORTS) begin
          res_action = mlst_pkg::ACT_UNICAST;
          res_port   = fin_flg.dst_port;
        end else begin
          res_action = mlst_pkg::ACT_NONE;
        end
      end else begin
        res_action = mlst_pkg::ACT_FLOOD;
      end
    end
  end

  // control and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inj_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      inj_r       <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (needs_scan) begin
              inj_r   <= 1'b1;
              state_r <= ST_SCAN;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.cmd        <= in_command;
      req_r.key        <= (in_command == mlst_pkg::CMD_DELETE) ? in_key_mac : in_src_mac;
      req_r.dst        <= in_dst_mac;
      req_r.port       <= in_in_port;
      req_r.dst_bcast  <= (in_dst_mac == mlst_pkg::MAC_BCAST);
      req_r.dst_is_src <= (in_dst_mac == in_src_mac);
      action_r         <= mlst_pkg::ACT_NONE;
      port_r           <= '0;
      changed_r        <= 1'b0;
      dropped_r        <= 1'b0;
    end else if (scan_done) begin
      action_r  <= res_action;
      port_r    <= res_port;
      changed_r <= res_changed;
      dropped_r <= res_dropped;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = action_r;
  assign out_out_port      = port_r;
  assign out_table_changed = changed_r;
  assign out_learn_dropped = dropped_r;

  // at most one cell holds the token at a time
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_w))
    else $error("more than one token in the cell row");

  // no token in flight outside a scan
  a_tok_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (tok_w == '0))
    else $error("token present while idle");

  // a finished scan is always followed by a result, with busy low
  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |=> (out_valid && !busy))
    else $error("scan ended without a result");

  // a dropped learn never changes the table and the frame is still forwarded
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_learn_dropped) |->
      (!out_table_changed && (out_action != mlst_pkg::ACT_NONE)))
    else $error("dropped learn with inconsistent result");

endmodule
